>>> src/prmt_pkg.sv
// shared constants and types for the prefix run mark tracker
`default_nettype none
package prmt_pkg;
  localparam int MaxPos = 4096;
  localparam int Slots = MaxPos + 1;
  localparam int AddrW = $clog2(Slots);
  localparam int ValW = 13;
  localparam logic [ValW-1:0] ActiveReset = ValW'(MaxPos);

  localparam logic [0:0] FuncMark = 1'b0;
  localparam logic [0:0] FuncQuery = 1'b1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [ValW-1:0] val_t;

  // one entry of the state memory
  typedef struct packed {
    addr_t parent;
    val_t  size;
    logic  marked;
  } entry_t;

  // memory port request
  typedef struct packed {
    logic   rd;
    addr_t  raddr;
    logic   wr;
    addr_t  waddr;
    entry_t wdata;
  } mem_req_t;
endpackage
`default_nettype wire

>>> src/prmt_store.sv
// state memory with one read and one write port and a clearing sweep after reset
`default_nettype none
module prmt_store (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  prmt_pkg::mem_req_t req_i,
  output prmt_pkg::entry_t   rdata_o,
  output logic               clear_done_o
);
  import prmt_pkg::*;

  entry_t mem [Slots];
  logic   clr_q, clr_d;
  addr_t  clr_addr_q, clr_addr_d;

  always_comb begin
    clr_d = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == addr_t'(Slots - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '{parent: clr_addr_q, size: val_t'(1), marked: 1'b0};
    end else if (req_i.wr) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

  assign clear_done_o = !clr_q;
endmodule
`default_nettype wire

>>> src/prmt_ctrl.sv
// sequencer: finds roots, compresses paths, merges runs and answers queries
`default_nettype none
module prmt_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire                func_i,
  input  prmt_pkg::val_t     position_i,
  input  prmt_pkg::val_t     n_i,
  input  wire                ready_i,
  output logic               busy_o,
  output prmt_pkg::mem_req_t req_o,
  input  prmt_pkg::entry_t   rdata_i,
  output logic               done_o,
  output prmt_pkg::val_t     first_gap_o
);
  import prmt_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SMarkRd = 4'd1;  // read entry b
  localparam logic [3:0] SMarkWr = 4'd2;  // set mark bit
  localparam logic [3:0] SNbrRd = 4'd3;   // read neighbour mark
  localparam logic [3:0] SFind = 4'd4;    // walk up to root
  localparam logic [3:0] SComp = 4'd5;    // compress path
  localparam logic [3:0] SSizeRd = 4'd6;  // size of found root
  localparam logic [3:0] SJoinWr = 4'd7;  // read root a
  localparam logic [3:0] SAddWr = 4'd8;   // query: mark of b+1
  localparam logic [3:0] SOut = 4'd9;
  localparam logic [3:0] SLinkWr = 4'd10; // link root a under root b
  localparam logic [3:0] SNext = 4'd11;   // right neighbour or done

  // what the current find serves
  localparam logic [2:0] JLeftA = 3'd0;
  localparam logic [2:0] JLeftB = 3'd1;
  localparam logic [2:0] JRightA = 3'd2;
  localparam logic [2:0] JRightB = 3'd3;
  localparam logic [2:0] QAnchor = 3'd4;
  localparam logic [2:0] QNext = 3'd5;

  logic [3:0] st_q, st_d;
  logic [2:0] job_q, job_d;
  val_t       b_q, b_d;
  addr_t      start_q, start_d;  // where the current find began
  addr_t      cur_q, cur_d;      // node being walked
  logic       rpend_q, rpend_d;  // read data valid this cycle
  addr_t      ra_q, ra_d;        // first root of a join
  addr_t      rb_q, rb_d;
  val_t       sa_q, sa_d;        // size of ra
  val_t       g_q, g_d;
  logic       nbr_q, nbr_d;      // 0 left, 1 right
  logic       out_q, out_d;
  val_t       res_q, res_d;
  mem_req_t   req;

  function automatic addr_t ta(input val_t v);
    return addr_t'(v);
  endfunction

  always_comb begin
    st_d = st_q; job_d = job_q; b_d = b_q;
    start_d = start_q; cur_d = cur_q; rpend_d = 1'b0;
    ra_d = ra_q; rb_d = rb_q; sa_d = sa_q; g_d = g_q; nbr_d = nbr_q;
    out_d = 1'b0; res_d = res_q;
    req = '0;
    case (st_q)
      SIdle: begin
        if (start_i && ready_i) begin
          b_d = position_i;
          if (func_i == FuncQuery) begin
            job_d = QAnchor; start_d = '0; cur_d = '0;
            req.rd = 1'b1; req.raddr = '0; rpend_d = 1'b1; st_d = SFind;
          end else if (position_i >= val_t'(1) && position_i <= n_i) begin
            req.rd = 1'b1; req.raddr = ta(position_i); st_d = SMarkRd;
          end
        end
      end
      SMarkRd: begin
        req.wr = 1'b1; req.waddr = ta(b_q);
        req.wdata = rdata_i; req.wdata.marked = 1'b1;
        st_d = SMarkWr;
      end
      SMarkWr: begin
        nbr_d = 1'b0;
        if (b_q == val_t'(1)) begin
          job_d = JLeftA; start_d = '0; cur_d = '0;
          req.rd = 1'b1; req.raddr = '0; rpend_d = 1'b1; st_d = SFind;
        end else begin
          req.rd = 1'b1; req.raddr = ta(b_q - val_t'(1)); st_d = SNbrRd;
        end
      end
      SNbrRd: begin
        if (rdata_i.marked) begin
          job_d = nbr_q ? JRightA : JLeftA;
          start_d = ta(b_q); cur_d = ta(b_q);
          req.rd = 1'b1; req.raddr = ta(b_q); rpend_d = 1'b1; st_d = SFind;
        end else if (!nbr_q && b_q < n_i) begin
          nbr_d = 1'b1;
          req.rd = 1'b1; req.raddr = ta(b_q + val_t'(1)); st_d = SNbrRd;
        end else begin
          st_d = SIdle;
        end
      end
      SFind: begin
        if (!rpend_q) begin
          req.rd = 1'b1; req.raddr = cur_q; rpend_d = 1'b1;
        end else if (rdata_i.parent != cur_q) begin
          cur_d = rdata_i.parent;
          req.rd = 1'b1; req.raddr = rdata_i.parent; rpend_d = 1'b1;
        end else begin
          // cur is root; compress from start
          cur_d = start_q;
          req.rd = 1'b1; req.raddr = start_q; rpend_d = 1'b1;
          start_d = cur_q;  // hold root in start
          st_d = SComp;
        end
      end
      SComp: begin
        // start_q holds root, cur_q the node read
        if (!rpend_q) begin
          req.rd = 1'b1; req.raddr = cur_q; rpend_d = 1'b1;
        end else if (cur_q != start_q && rdata_i.parent != start_q) begin
          req.wr = 1'b1; req.waddr = cur_q;
          req.wdata = rdata_i; req.wdata.parent = start_q;
          cur_d = rdata_i.parent;
          // read next after write settles
          rpend_d = 1'b0;
        end else begin
          req.rd = 1'b1; req.raddr = start_q; st_d = SSizeRd;
        end
      end
      SSizeRd: begin
        case (job_q)
          JLeftA, JRightA: begin
            ra_d = start_q; sa_d = rdata_i.size;
            job_d = (job_q == JLeftA) ? JLeftB : JRightB;
            if (job_q == JLeftA && b_q == val_t'(1)) begin
              start_d = addr_t'(1); cur_d = addr_t'(1);
              req.rd = 1'b1; req.raddr = addr_t'(1);
            end else if (job_q == JLeftA) begin
              start_d = ta(b_q - val_t'(1)); cur_d = ta(b_q - val_t'(1));
              req.rd = 1'b1; req.raddr = ta(b_q - val_t'(1));
            end else begin
              start_d = ta(b_q + val_t'(1)); cur_d = ta(b_q + val_t'(1));
              req.rd = 1'b1; req.raddr = ta(b_q + val_t'(1));
            end
            rpend_d = 1'b1; st_d = SFind;
          end
          JLeftB, JRightB: begin
            rb_d = start_q;
            if (start_q != ra_q) begin
              req.wr = 1'b1; req.waddr = start_q;
              req.wdata = rdata_i; req.wdata.size = rdata_i.size + sa_q;
            end
            st_d = SJoinWr;
          end
          QAnchor: begin
            g_d = rdata_i.size;
            if (rdata_i.size != b_q) begin
              out_d = 1'b1; res_d = rdata_i.size; st_d = SOut;
            end else if (b_q >= n_i) begin
              st_d = SIdle;
            end else begin
              req.rd = 1'b1; req.raddr = ta(b_q + val_t'(1)); st_d = SAddWr;
            end
          end
          default: begin  // QNext
            out_d = 1'b1; res_d = g_q + val_t'(1) + rdata_i.size; st_d = SOut;
          end
        endcase
      end
      SJoinWr: begin
        if (rb_q != ra_q) begin
          req.rd = 1'b1; req.raddr = ra_q;
          st_d = SLinkWr;
        end else begin
          st_d = SNext;
        end
      end
      SLinkWr: begin
        req.wr = 1'b1; req.waddr = ra_q;
        req.wdata = rdata_i; req.wdata.parent = rb_q;
        st_d = SNext;
      end
      SNext: begin
        if (job_q == JLeftB && b_q < n_i) begin
          nbr_d = 1'b1;
          req.rd = 1'b1; req.raddr = ta(b_q + val_t'(1)); st_d = SNbrRd;
        end else begin
          st_d = SIdle;
        end
      end
      SAddWr: begin
        // mark of b+1 read
        if (!rdata_i.marked) begin
          out_d = 1'b1; res_d = g_q + val_t'(1); st_d = SOut;
        end else begin
          job_d = QNext; start_d = ta(b_q + val_t'(1)); cur_d = ta(b_q + val_t'(1));
          req.rd = 1'b1; req.raddr = ta(b_q + val_t'(1)); rpend_d = 1'b1; st_d = SFind;
        end
      end
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; rpend_q <= 1'b0; out_q <= 1'b0;
    end else begin
      st_q <= st_d; rpend_q <= rpend_d; out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; b_q <= b_d; start_q <= start_d;
    cur_q <= cur_d; ra_q <= ra_d; rb_q <= rb_d; sa_q <= sa_d; g_q <= g_d;
    nbr_q <= nbr_d; res_q <= res_d;
  end

  assign busy_o = (st_q != SIdle) || !ready_i;
  assign req_o = req;
  assign done_o = out_q;
  assign first_gap_o = res_q;
endmodule
`default_nettype wire

>>> src/prefix_run_mark_tracker_unit.sv
// top level of the prefix run mark tracker
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  command   | start / busy         | func_i, position_i
//  result    | result_valid_o       | first_gap_o
//  config    | cfg_valid_i/cfg_ready_o | cfg_data_i (active_positions)
//
// a find walks parent links one read at a time, then rewrites each link on its path to the root
// a query runs one find, or two when it reaches past b and b+1 is marked, and strobes its
//   result, when it gives one, in its last busy cycle
// a mark reads its entry, sets its mark bit and reads neighbour marks; each merge adds two finds
// walks are serial since each memory read address comes from the previous read
// after reset a clearing sweep over all 4097 entries runs; busy is high then
// the result strobe lasts one cycle and cannot be stalled
`default_nettype none
module prefix_run_mark_tracker_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  wire                  func_i,
  input  prmt_pkg::val_t       position_i,
  output logic                 result_valid_o,
  output prmt_pkg::val_t       first_gap_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  prmt_pkg::val_t       cfg_data_i
);
  import prmt_pkg::*;

  val_t     n_q;
  mem_req_t req;
  entry_t   rdata;
  logic     clear_done;

  // clamp register writes into 1..MaxPos
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= ActiveReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        n_q <= val_t'(1);
      end else if (cfg_data_i > ActiveReset) begin
        n_q <= ActiveReset;
      end else begin
        n_q <= cfg_data_i;
      end
    end
  end
  assign cfg_ready_o = 1'b1;

  prmt_store u_store (
    .clk_i, .rst_ni, .req_i(req), .rdata_o(rdata), .clear_done_o(clear_done)
  );

  prmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i, .position_i, .n_i(n_q),
    .ready_i(clear_done), .busy_o(busy), .req_o(req), .rdata_i(rdata),
    .done_o(result_valid_o), .first_gap_o
  );

  // no command is taken during the clearing sweep
  a_no_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clear_done |-> busy) else $error("busy low during clear");
  // a result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe too long");
  // answer is never zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> first_gap_o != '0) else $error("zero gap");
endmodule
`default_nettype wire

>>> dv/prmt_gap_checker.sv
// checker for the prefix run mark tracker: predicts first gaps and compares results
module prmt_gap_checker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  input  wire                  busy,
  input  wire                  func_i,
  input  prmt_pkg::val_t       position_i,
  input  wire                  result_valid_o,
  input  prmt_pkg::val_t       first_gap_o,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_o,
  input  prmt_pkg::val_t       cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          gaps_pending_o
);
  import prmt_pkg::*;

  localparam int FifoDepth = 16;

  int unsigned link_q [Slots];
  int unsigned run_len_q [Slots];
  bit          marked_q [Slots];
  int unsigned n_active;
  val_t        gap_fifo_q [FifoDepth];
  int unsigned wr_cnt;
  int unsigned rd_cnt;

  function automatic int unsigned clamp_count(val_t v);
    if (v == 0) return 1;
    if (v > MaxPos) return MaxPos;
    return 32'(v);
  endfunction

  function automatic int unsigned run_root(int unsigned x);
    int unsigned r;
    int unsigned nx;
    r = x;
    while (link_q[r] != r) r = link_q[r];
    while (x != r) begin
      nx = link_q[x];
      link_q[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic void merge_runs(int unsigned x, int unsigned y);
    int unsigned rx;
    int unsigned ry;
    rx = run_root(x);
    ry = run_root(y);
    if (rx == ry) return;
    link_q[rx] = ry;
    run_len_q[ry] += run_len_q[rx];
  endfunction

  // returns 1 and the gap when the item gives a result
  function automatic bit apply_item(logic fn, val_t pos, output val_t gap);
    int unsigned b;
    int unsigned g;
    b = 32'(pos);
    gap = '0;
    if (fn == FuncMark) begin
      if (b < 1 || b > n_active) return 0;
      marked_q[b] = 1'b1;
      if (b == 1) merge_runs(0, 1);
      else if (marked_q[b-1]) merge_runs(b, b - 1);
      if (b + 1 <= n_active && marked_q[b+1]) merge_runs(b, b + 1);
      return 0;
    end
    g = run_len_q[run_root(0)];
    if (g != b) begin
      gap = val_t'(g);
      return 1;
    end
    if (b + 1 > n_active) return 0;
    if (!marked_q[b+1]) gap = val_t'(g + 1);
    else gap = val_t'(g + 1 + run_len_q[run_root(b + 1)]);
    return 1;
  endfunction

  assign gaps_pending_o = wr_cnt - rd_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    val_t gap;
    val_t exp_gap;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        link_q[i] = i;
        run_len_q[i] = 1;
        marked_q[i] = 1'b0;
      end
      n_active = clamp_count(ActiveReset);
      wr_cnt = 0;
      rd_cnt = 0;
      fail_count_o <= 0;
    end else begin
      // result strobe first: a result cannot come from a command accepted at this edge
      if (result_valid_o) begin
        if (wr_cnt == rd_cnt) begin
          if (fail_count_o < 10)
            $display("unexpected result first_gap=%0d", first_gap_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_gap = gap_fifo_q[rd_cnt[3:0]];
          rd_cnt = rd_cnt + 1;
          if (exp_gap !== first_gap_o) begin
            if (fail_count_o < 10)
              $display("first_gap mismatch: expected %0d actual %0d", exp_gap, first_gap_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) n_active = clamp_count(cfg_data_i);
      if (start && !busy) begin
        if (apply_item(func_i, position_i, gap)) begin
          gap_fifo_q[wr_cnt[3:0]] = gap;
          wr_cnt = wr_cnt + 1;
        end
      end
    end
  end
endmodule

>>> dv/prefix_run_mark_tracker_unit_tb.sv
// testbench top for the prefix run mark tracker: stimulus and verdict
module prefix_run_mark_tracker_unit_tb;
  import prmt_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int DrainCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        func_i = FuncMark;
  val_t        position_i = '0;
  logic        cfg_valid_i = 1'b0;
  val_t        cfg_data_i = '0;
  wire         busy;
  wire         result_valid_o;
  val_t        first_gap_o;
  wire         cfg_ready_o;
  int unsigned fail_count;
  int unsigned gaps_pending;
  int unsigned cycle_count = 0;
  bit          idling_on = 1'b1;

  always #5 clk_i = ~clk_i;

  prefix_run_mark_tracker_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .position_i,
    .result_valid_o, .first_gap_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  prmt_gap_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .func_i, .position_i,
    .result_valid_o, .first_gap_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .gaps_pending_o(gaps_pending)
  );

  // watchdog: clearing sweep plus worst walks fit well inside this
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[prefix_run_mark_tracker_unit] ERROR");
      $finish;
    end
  end

  // one command transfer; start stays high across back-to-back items
  task automatic send_cmd(logic fn, val_t pos);
    int gap;
    start <= 1'b1;
    func_i <= fn;
    position_i <= pos;
    @(posedge clk_i iff !busy);
    // random sender gaps: now and then start drops before the next item
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every expected gap has come and any trailing mark has finished
  task automatic drain_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (gaps_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_count(val_t v);
    drain_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i iff cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly marks and queries in a small window near the filled prefix, some noise
  task automatic random_phase(int items, int unsigned window);
    int unsigned pick;
    val_t pos;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) pos = val_t'($urandom);
      else pos = val_t'($urandom_range(1, window + 2));
      send_cmd((pick % 2 == 0) ? FuncMark : FuncQuery, pos);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing sweep holds busy high; send_cmd waits on it

    // directed: empty store, extremes, the anchor and repeated marks
    send_cmd(FuncQuery, 13'd1);      // g equals b at 1
    send_cmd(FuncQuery, 13'd0);      // position 0 query
    send_cmd(FuncMark, 13'd0);       // ignored mark
    send_cmd(FuncMark, 13'd8191);    // above n, ignored
    send_cmd(FuncQuery, 13'd8191);   // query above n
    send_cmd(FuncMark, 13'd2);       // run not yet tied to anchor
    send_cmd(FuncQuery, 13'd1);      // g=b with marked neighbour
    send_cmd(FuncMark, 13'd1);       // joins anchor
    send_cmd(FuncMark, 13'd1);       // repeated mark
    send_cmd(FuncQuery, 13'd3);
    send_cmd(FuncMark, 13'd4096);    // top position
    send_cmd(FuncQuery, 13'd4096);
    send_cmd(FuncQuery, 13'd4095);
    send_cmd(FuncMark, 13'd4);
    send_cmd(FuncMark, 13'd3);       // bridges two runs
    send_cmd(FuncQuery, 13'd5);
    send_cmd(FuncQuery, 13'd6);

    // register at its extremes, then several settings
    write_count(13'd0);              // taken as 1
    send_cmd(FuncMark, 13'd5);       // above n now, ignored
    send_cmd(FuncQuery, 13'd5);
    send_cmd(FuncQuery, 13'd1);
    write_count(13'd8191);           // taken as the maximum
    random_phase(300, 24);
    write_count(13'd1);
    random_phase(100, 4);
    write_count(13'd40);
    random_phase(300, 48);
    write_count(13'd2);
    random_phase(100, 4);
    write_count(13'd300);
    random_phase(500, 300);
    write_count(13'd4096);
    random_phase(300, 400);
    // last part without idling
    idling_on = 1'b0;
    random_phase(300, 500);

    drain_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[prefix_run_mark_tracker_unit] OK");
    end else begin
      $display("[prefix_run_mark_tracker_unit] ERROR");
    end
    $finish;
  end
endmodule
